// ===== hdl/lptl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptl_pkg
// Shared types and constants of the LED power and thermal limiter.
// ----------------------------------------------------------------------------
package lptl_pkg;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_SCALE   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam int unsigned REG_RED   = 0;
  localparam int unsigned REG_GREEN = 1;
  localparam int unsigned REG_BLUE  = 2;
  localparam int unsigned REG_VOLT  = 3;
  localparam int unsigned REG_LIMIT = 4;
  localparam int unsigned REG_HIGH  = 5;
  localparam int unsigned REG_CUT   = 6;
  localparam int unsigned NUM_REGS  = 7;

  localparam logic [16:0] Q_ONE   = 17'h10000;
  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;
  localparam int unsigned QUO_W   = 18;
  localparam int unsigned DEN_W   = 52;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  reg_sel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] temp;
  } item_t;

  typedef struct packed {
    logic [7:0]  red_cur;
    logic [7:0]  green_cur;
    logic [7:0]  blue_cur;
    logic [15:0] volt;
    logic [7:0]  limit;
    logic [7:0]  high_t;
    logic [7:0]  cut_t;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PDIV,
    ST_TDIV,
    ST_SCALE1,
    ST_SCALE2,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/lptl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptl_front
// Accepts transactions, maps the regulator index and queues them.
// ----------------------------------------------------------------------------
module lptl_front #(
  parameter int unsigned REGULATORS = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  lptl_pkg::item_t in_item,
  input  logic            pop,
  output logic            q_empty,
  output lptl_pkg::item_t q_item
);
  import lptl_pkg::*;

  item_t     mem_r [2];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t     it;
  logic      do_push;

  always_comb begin
    it = in_item;
    if (32'(in_item.reg_sel) >= REGULATORS) begin
      it.reg_sel = 3'd0;
    end
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_item  = mem_r[rp_r];
  assign do_push = in_push && !in_full && (in_item.cmd != CMD_NONE);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = ~wp_r;
    end
    if (pop && !q_empty) begin
      rp_nxt = ~rp_r;
    end
    cnt_nxt = cnt_r + 2'(do_push) - 2'(pop && !q_empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= it;
    end
  end

endmodule

// ===== hdl/lptl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptl_div
// Restoring divider, one quotient bit per cycle, quotient saturated to one.
// ----------------------------------------------------------------------------
module lptl_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lptl_pkg::DEN_W-1:0]       num,
  input  logic [lptl_pkg::DEN_W-1:0]       den,
  output logic                             done,
  output logic [16:0]                      quo
);
  import lptl_pkg::*;

  // first step tests num >= 2^(QUO_W-1) * den; if so the quotient saturates
  logic [DEN_W+QUO_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0]       den_r;
  logic [QUO_W-1:0]       q_r, q_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt, sat_r;
  logic [DEN_W+QUO_W:0]   diff;

  assign diff = {1'b0, rem_r} - {1'b0, den_r, {QUO_W{1'b0}}} ;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (!diff[DEN_W+QUO_W]) begin
        rem_nxt = diff[DEN_W+QUO_W-1:0] << 1;
        q_nxt   = {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_r << 1;
        q_nxt   = {q_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= busy_r && (cnt_r == 5'd0);
      busy_r <= start ? 1'b1 : busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {{(QUO_W-1){1'b0}}, num, 1'b0};
      den_r <= den;
      q_r   <= '0;
      cnt_r <= 5'(QUO_W - 1);
      sat_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_nxt;
      if (busy_r && cnt_r == 5'(QUO_W - 1) && !diff[DEN_W+QUO_W]) begin
        sat_r <= 1'b1;
      end
    end
  end

  assign quo = (sat_r || q_r > QUO_W'(Q_ONE)) ? Q_ONE : q_r[16:0];

endmodule

// ===== hdl/lptl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptl_back
// Executes queued transactions: load sums, factor division and scaling.
// ----------------------------------------------------------------------------
module lptl_back #(
  parameter int unsigned REGULATORS = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lptl_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  lptl_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [16:0]     out_pf,
  output logic [16:0]     out_tf
);
  import lptl_pkg::*;

  localparam int unsigned RW = (REGULATORS > 1) ? $clog2(REGULATORS) : 1;

  state_t      st_r, st_nxt;
  logic [31:0] sum_r [REGULATORS];
  logic [11:0] temp_r;
  item_t       cur_r;
  logic [RW-1:0] ri;
  logic [31:0] sel_sum;
  logic [33:0] step_r;
  logic [47:0] sv_r;
  logic [16:0] pf_r, tf_r;
  logic [7:0]  r1_r, g1_r, b1_r;
  logic        dstart;
  logic [DEN_W-1:0] dnum, dden;
  logic        ddone;
  logic [16:0] dquo;
  logic        tspecial, tdir;
  logic signed [13:0] t_s, hi_s, co_s, tn, td;
  logic [16:0] tdirv;
  logic [34:0] acc;
  logic        full_r;

  assign ri      = cur_r.reg_sel[RW-1:0];
  assign sel_sum = sum_r[ri];
  assign acc     = {1'b0, step_r} + {3'b0, sel_sum};

  assign t_s  = 14'(signed'(temp_r));
  assign hi_s = 14'(cfg.high_t) * 14'sd10;
  assign co_s = 14'(cfg.cut_t) * 14'sd10;
  assign tn   = co_s - t_s;
  assign td   = co_s - hi_s;
  always_comb begin
    tspecial = 1'b1;
    tdirv    = Q_ONE;
    if (co_s <= hi_s) begin
      tdirv = (t_s <= hi_s) ? Q_ONE : 17'd0;
    end else if (tn <= 0) begin
      tdirv = 17'd0;
    end else if (tn >= td) begin
      tdirv = Q_ONE;
    end else begin
      tspecial = 1'b0;
    end
  end

  always_comb begin
    dstart = 1'b0;
    dnum   = '0;
    dden   = '0;
    tdir   = 1'b0;
    st_nxt = st_r;
    q_pop  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        unique case (cur_r.cmd)
          CMD_SCALE: begin
            if (sv_r == 48'd0) begin
              st_nxt = ST_TDIV;
            end else begin
              dstart = 1'b1;
              dnum   = DEN_W'(64'(cfg.limit) * 64'd255000 * 64'd65536);
              dden   = DEN_W'(sv_r) * DEN_W'(REGULATORS);
              st_nxt = ST_PDIV;
            end
          end
          default: st_nxt = ST_IDLE;
        endcase
      end
      ST_PDIV: begin
        if (ddone) begin
          st_nxt = ST_TDIV;
          tdir   = 1'b1;
        end
      end
      ST_TDIV: begin
        if (!tdir && tspecial) begin
          st_nxt = ST_SCALE1;
        end else if (ddone) begin
          st_nxt = ST_SCALE1;
        end
      end
      ST_SCALE1: st_nxt = ST_SCALE2;
      ST_SCALE2: st_nxt = ST_OUT;
      ST_OUT: begin
        if (!full_r) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic tstart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      temp_r   <= '0;
      full_r   <= 1'b0;
      tstart_r <= 1'b0;
      for (int i = 0; i < REGULATORS; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      tstart_r <= 1'b0;
      if (st_r == ST_OUT && !full_r) begin
        full_r <= 1'b1;
      end else if (out_pop && full_r) begin
        full_r <= 1'b0;
      end
      if (st_r == ST_MUL && cur_r.cmd == CMD_START) begin
        temp_r <= cur_r.temp;
        for (int i = 0; i < REGULATORS; i++) begin
          sum_r[i] <= '0;
        end
      end
      if (st_r == ST_MUL && cur_r.cmd == CMD_MEASURE) begin
        sum_r[ri] <= acc[34:32] != 3'd0 ? SUM_MAX : acc[31:0];
      end
      if (st_nxt == ST_TDIV && st_r != ST_TDIV && !tspecial) begin
        tstart_r <= 1'b1;
      end
    end
  end

  logic tbusy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbusy_r <= 1'b0;
    end else if (st_r != ST_TDIV) begin
      tbusy_r <= 1'b0;
    end else if (tstart_r) begin
      tbusy_r <= 1'b1;
    end
  end

  logic        dgo;
  logic [DEN_W-1:0] gnum, gden;
  always_comb begin
    dgo  = dstart;
    gnum = dnum;
    gden = dden;
    if (tstart_r) begin
      dgo  = 1'b1;
      gnum = DEN_W'(tn) << 16;
      gden = DEN_W'(td);
    end
  end

  lptl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dgo),
    .num   (gnum),
    .den   (gden),
    .done  (ddone),
    .quo   (dquo)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (st_r == ST_IDLE) begin
      step_r <= 34'(16'(cfg.red_cur) * 16'(q_item.red))
              + 34'(16'(cfg.green_cur) * 16'(q_item.green))
              + 34'(16'(cfg.blue_cur) * 16'(q_item.blue));
      sv_r   <= 48'(sum_r[q_item.reg_sel[RW-1:0]]) * 48'(cfg.volt);
    end
    if (st_r == ST_MUL) begin
      pf_r <= Q_ONE;
    end
    if (st_r == ST_PDIV && ddone) begin
      pf_r <= dquo;
    end
    if (st_r == ST_TDIV && st_nxt == ST_SCALE1) begin
      tf_r <= (tbusy_r && ddone) ? dquo : tdirv;
    end
    if (st_r == ST_SCALE1) begin
      r1_r <= 8'((25'(cur_r.red) * 25'(pf_r)) >> 16);
      g1_r <= 8'((25'(cur_r.green) * 25'(pf_r)) >> 16);
      b1_r <= 8'((25'(cur_r.blue) * 25'(pf_r)) >> 16);
    end
    if (st_r == ST_OUT && !full_r) begin
      out_red   <= 8'((25'(r1_r) * 25'(tf_r)) >> 16);
      out_green <= 8'((25'(g1_r) * 25'(tf_r)) >> 16);
      out_blue  <= 8'((25'(b1_r) * 25'(tf_r)) >> 16);
      out_pf    <= pf_r;
      out_tf    <= tf_r;
    end
  end

  assign out_empty = !full_r;

endmodule

// ===== hdl/led_power_thermal_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_power_thermal_limiter
// Per-regulator load metering with power and thermal derating of pixels.
// ----------------------------------------------------------------------------
// Start and measure transactions need no divide in the back end. A scale
// transaction needs one divide for each factor it computes on the shared
// 18-step serial divider: the power factor unless load or supply voltage is
// zero, the thermal factor unless the temperature is outside the range between
// the high and cutoff limits. A two-entry queue decouples input from execution;
// results wait in an output register until popped, which stalls the back end.
module led_power_thermal_limiter #(
  parameter int unsigned REGULATORS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_regulator_index,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic signed [11:0] in_temperature_tenths,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [16:0] out_power_factor,
  output logic [16:0] out_thermal_factor,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lptl_pkg::*;

  cfg_t  cfg_r;
  item_t in_item, q_item;
  logic  q_empty, q_pop;
  logic  wr;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{red_cur: 8'd20, green_cur: 8'd20, blue_cur: 8'd20, volt: 16'd5000,
                 limit: 8'd10, high_t: 8'd60, cut_t: 8'd80};
    end else if (wr) begin
      unique case (32'(ridx))
        REG_RED:   cfg_r.red_cur   <= cfg_pwdata[7:0];
        REG_GREEN: cfg_r.green_cur <= cfg_pwdata[7:0];
        REG_BLUE:  cfg_r.blue_cur  <= cfg_pwdata[7:0];
        REG_VOLT:  cfg_r.volt      <= cfg_pwdata[15:0];
        REG_LIMIT: cfg_r.limit     <= cfg_pwdata[7:0];
        REG_HIGH:  cfg_r.high_t    <= cfg_pwdata[7:0];
        REG_CUT:   cfg_r.cut_t     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (32'(ridx))
      REG_RED:   cfg_prdata = 32'(cfg_r.red_cur);
      REG_GREEN: cfg_prdata = 32'(cfg_r.green_cur);
      REG_BLUE:  cfg_prdata = 32'(cfg_r.blue_cur);
      REG_VOLT:  cfg_prdata = 32'(cfg_r.volt);
      REG_LIMIT: cfg_prdata = 32'(cfg_r.limit);
      REG_HIGH:  cfg_prdata = 32'(cfg_r.high_t);
      REG_CUT:   cfg_prdata = 32'(cfg_r.cut_t);
      default:   cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    in_item.cmd     = cmd_t'(in_command);
    in_item.reg_sel = in_regulator_index;
    in_item.red     = in_red_in;
    in_item.green   = in_green_in;
    in_item.blue    = in_blue_in;
    in_item.temp    = in_temperature_tenths;
  end

  lptl_front #(.REGULATORS(REGULATORS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (push),
    .in_full (full),
    .in_item (in_item),
    .pop     (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  lptl_back #(.REGULATORS(REGULATORS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_red   (out_red_out),
    .out_green (out_green_out),
    .out_blue  (out_blue_out),
    .out_pf    (out_power_factor),
    .out_tf    (out_thermal_factor)
  );

`ifndef SYNTHESIS
  a_pf_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_power_factor <= Q_ONE) else $error("power factor above one");
  a_tf_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_thermal_factor <= Q_ONE) else $error("thermal factor above one");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty && $stable(out_red_out)) else $error("result lost");
`endif

endmodule
